>>> hdl/chunk_request_window_scheduler_unit_macros.svh
// Assertion macros for the chunk request window scheduler.
`ifndef CHUNK_REQUEST_WINDOW_SCHEDULER_UNIT_MACROS_SVH
`define CHUNK_REQUEST_WINDOW_SCHEDULER_UNIT_MACROS_SVH
`ifndef SYNTH
`define CRWS_AST_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CRWS_AST_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CRWS_AST_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CRWS_AST_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/crws_pkg.sv
// Types and codes shared by the chunk request window scheduler modules.
package crws_pkg;

    localparam logic [2:0] MODE_START    = 3'd0;
    localparam logic [2:0] MODE_NEXT     = 3'd1;
    localparam logic [2:0] MODE_COMPLETE = 3'd2;
    localparam logic [2:0] MODE_CHECK    = 3'd3;
    localparam logic [2:0] MODE_UNISSUE  = 3'd4;
    localparam logic [2:0] MODE_CANCEL   = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_REJECTED  = 3'd1;
    localparam logic [2:0] ST_REQUEST   = 3'd2;
    localparam logic [2:0] ST_WAIT      = 3'd3;
    localparam logic [2:0] ST_COMPLETE  = 3'd4;
    localparam logic [2:0] ST_EXHAUSTED = 3'd5;
    localparam logic [2:0] ST_CANCELLED = 3'd6;
    localparam logic [2:0] ST_INVALID   = 3'd7;

    localparam logic [1:0] REG_NUM_CHUNKS   = 2'd0;
    localparam logic [1:0] REG_FIRST_ID     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT      = 2'd2;
    localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] now_ms;
        logic [9:0]  chunk_sel;
        logic [63:0] req_tag;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] issued_tag;
        logic [63:0] due_ms;
        logic [9:0]  issued_chunk;
        logic [7:0]  attempt_number;
    } t_out;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_START_INIT, OP_CLR_ALL, OP_CANCEL_INIT, OP_CLR_INFL,
        OP_RST_IDX, OP_SLOT_RD, OP_EXP_CHK, OP_SCAN_RD, OP_CHUNK_RD, OP_CIDX_INC,
        OP_SIDX_INC, OP_ISSUE, OP_CMP_RD, OP_CMP_MARK, OP_CMP_CHK, OP_UNI_HIT,
        OP_UNI_DO, OP_RESULT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] status;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic start_ok;
        logic next_invalid;
        logic cancelled;
        logic cmp_ok;
        logic chk_ok;
        logic uni_ok;
        logic all_held;
        logic window_full;
        logic cand;
        logic visits_done;
        logic exh;
        logic cidx_last;
        logic clr_last;
        logic sidx_last;
        logic slot_valid;
        logic chk_hit;
        logic uni_hit;
        logic att_zero;
        logic overflow;
    } t_stat;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_CLR_ALL, S_CLR_INFL, S_DONE_OK, S_EXP_RD, S_EXP_CHK,
        S_NEXT_DEC, S_SCAN_RD, S_SCAN_CHK, S_EXH_RD, S_EXH_CHK, S_ISSUE_CHK,
        S_FREE, S_CMP_MARK, S_CMP_RD, S_CMP_CHK, S_CHK_RD, S_CHK_CHK, S_UNI_RD,
        S_UNI_CHK, S_UNI_DO
    } t_state;

endpackage

>>> hdl/crws_ctrl.sv
// Sequencing state machine of the chunk request window scheduler.
module crws_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  crws_pkg::t_stat i_stat,
    output logic            busy,
    output crws_pkg::t_cmd  o_cmd
);

    crws_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crws_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != crws_pkg::S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            crws_pkg::S_IDLE: begin
                if (start) n_state = crws_pkg::S_DISP;
            end
            crws_pkg::S_DISP: begin
                n_state = crws_pkg::S_IDLE;
                case (i_stat.mode)
                    crws_pkg::MODE_START: begin
                        if (i_stat.start_ok) n_state = crws_pkg::S_CLR_ALL;
                    end
                    crws_pkg::MODE_NEXT: begin
                        if (!i_stat.next_invalid && !i_stat.cancelled)
                            n_state = crws_pkg::S_EXP_RD;
                    end
                    crws_pkg::MODE_COMPLETE: begin
                        if (i_stat.cmp_ok) n_state = crws_pkg::S_CMP_MARK;
                    end
                    crws_pkg::MODE_CHECK: begin
                        if (i_stat.chk_ok) n_state = crws_pkg::S_CHK_RD;
                    end
                    crws_pkg::MODE_UNISSUE: begin
                        if (i_stat.uni_ok) n_state = crws_pkg::S_UNI_RD;
                    end
                    crws_pkg::MODE_CANCEL: n_state = crws_pkg::S_CLR_INFL;
                    default: n_state = crws_pkg::S_IDLE;
                endcase
            end
            crws_pkg::S_CLR_ALL: begin
                if (i_stat.clr_last) n_state = crws_pkg::S_DONE_OK;
            end
            crws_pkg::S_CLR_INFL: begin
                if (i_stat.clr_last) n_state = crws_pkg::S_DONE_OK;
            end
            crws_pkg::S_DONE_OK: n_state = crws_pkg::S_IDLE;
            crws_pkg::S_EXP_RD:  n_state = crws_pkg::S_EXP_CHK;
            crws_pkg::S_EXP_CHK: begin
                n_state = i_stat.sidx_last ? crws_pkg::S_NEXT_DEC : crws_pkg::S_EXP_RD;
            end
            crws_pkg::S_NEXT_DEC: begin
                if (i_stat.all_held || i_stat.window_full) n_state = crws_pkg::S_IDLE;
                else n_state = crws_pkg::S_SCAN_RD;
            end
            crws_pkg::S_SCAN_RD: n_state = crws_pkg::S_SCAN_CHK;
            crws_pkg::S_SCAN_CHK: begin
                if (i_stat.cand) n_state = crws_pkg::S_ISSUE_CHK;
                else if (i_stat.visits_done) n_state = crws_pkg::S_EXH_RD;
                else n_state = crws_pkg::S_SCAN_RD;
            end
            crws_pkg::S_EXH_RD: n_state = crws_pkg::S_EXH_CHK;
            crws_pkg::S_EXH_CHK: begin
                if (i_stat.exh || i_stat.cidx_last) n_state = crws_pkg::S_IDLE;
                else n_state = crws_pkg::S_EXH_RD;
            end
            crws_pkg::S_ISSUE_CHK: begin
                n_state = i_stat.overflow ? crws_pkg::S_IDLE : crws_pkg::S_FREE;
            end
            crws_pkg::S_FREE: begin
                if (!i_stat.slot_valid || i_stat.sidx_last) n_state = crws_pkg::S_IDLE;
            end
            crws_pkg::S_CMP_MARK: n_state = crws_pkg::S_CMP_RD;
            crws_pkg::S_CMP_RD:   n_state = crws_pkg::S_CMP_CHK;
            crws_pkg::S_CMP_CHK: begin
                n_state = i_stat.sidx_last ? crws_pkg::S_DONE_OK : crws_pkg::S_CMP_RD;
            end
            crws_pkg::S_CHK_RD: n_state = crws_pkg::S_CHK_CHK;
            crws_pkg::S_CHK_CHK: begin
                if (i_stat.chk_hit || i_stat.sidx_last) n_state = crws_pkg::S_IDLE;
                else n_state = crws_pkg::S_CHK_RD;
            end
            crws_pkg::S_UNI_RD: n_state = crws_pkg::S_UNI_CHK;
            crws_pkg::S_UNI_CHK: begin
                if (i_stat.uni_hit) n_state = crws_pkg::S_UNI_DO;
                else if (i_stat.sidx_last) n_state = crws_pkg::S_IDLE;
                else n_state = crws_pkg::S_UNI_RD;
            end
            crws_pkg::S_UNI_DO: begin
                n_state = i_stat.att_zero ? crws_pkg::S_IDLE : crws_pkg::S_DONE_OK;
            end
            default: n_state = crws_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.op     = crws_pkg::OP_NONE;
        o_cmd.status = crws_pkg::ST_REJECTED;
        unique case (r_state)
            crws_pkg::S_IDLE: begin
                if (start) o_cmd.op = crws_pkg::OP_LOAD;
            end
            crws_pkg::S_DISP: begin
                o_cmd.op = crws_pkg::OP_RESULT;
                case (i_stat.mode)
                    crws_pkg::MODE_START: begin
                        if (i_stat.start_ok) o_cmd.op = crws_pkg::OP_START_INIT;
                    end
                    crws_pkg::MODE_NEXT: begin
                        if (i_stat.next_invalid) o_cmd.status = crws_pkg::ST_INVALID;
                        else if (i_stat.cancelled) o_cmd.status = crws_pkg::ST_CANCELLED;
                        else o_cmd.op = crws_pkg::OP_RST_IDX;
                    end
                    crws_pkg::MODE_COMPLETE: begin
                        if (i_stat.cmp_ok) o_cmd.op = crws_pkg::OP_CMP_RD;
                    end
                    crws_pkg::MODE_CHECK: begin
                        if (i_stat.chk_ok) o_cmd.op = crws_pkg::OP_RST_IDX;
                    end
                    crws_pkg::MODE_UNISSUE: begin
                        if (i_stat.uni_ok) o_cmd.op = crws_pkg::OP_RST_IDX;
                    end
                    crws_pkg::MODE_CANCEL: o_cmd.op = crws_pkg::OP_CANCEL_INIT;
                    default: o_cmd.op = crws_pkg::OP_RESULT;
                endcase
            end
            crws_pkg::S_CLR_ALL:  o_cmd.op = crws_pkg::OP_CLR_ALL;
            crws_pkg::S_CLR_INFL: o_cmd.op = crws_pkg::OP_CLR_INFL;
            crws_pkg::S_DONE_OK: begin
                o_cmd.op     = crws_pkg::OP_RESULT;
                o_cmd.status = crws_pkg::ST_OK;
            end
            crws_pkg::S_EXP_RD:  o_cmd.op = crws_pkg::OP_SLOT_RD;
            crws_pkg::S_EXP_CHK: o_cmd.op = crws_pkg::OP_EXP_CHK;
            crws_pkg::S_NEXT_DEC: begin
                if (i_stat.all_held) begin
                    o_cmd.op     = crws_pkg::OP_RESULT;
                    o_cmd.status = crws_pkg::ST_COMPLETE;
                end else if (i_stat.window_full) begin
                    o_cmd.op     = crws_pkg::OP_RESULT;
                    o_cmd.status = crws_pkg::ST_WAIT;
                end else begin
                    o_cmd.op = crws_pkg::OP_RST_IDX;
                end
            end
            crws_pkg::S_SCAN_RD: o_cmd.op = crws_pkg::OP_SCAN_RD;
            crws_pkg::S_SCAN_CHK: begin
                if (!i_stat.cand && i_stat.visits_done) o_cmd.op = crws_pkg::OP_RST_IDX;
            end
            crws_pkg::S_EXH_RD: o_cmd.op = crws_pkg::OP_CHUNK_RD;
            crws_pkg::S_EXH_CHK: begin
                if (i_stat.exh) begin
                    o_cmd.op     = crws_pkg::OP_RESULT;
                    o_cmd.status = crws_pkg::ST_EXHAUSTED;
                end else if (i_stat.cidx_last) begin
                    o_cmd.op     = crws_pkg::OP_RESULT;
                    o_cmd.status = crws_pkg::ST_WAIT;
                end else begin
                    o_cmd.op = crws_pkg::OP_CIDX_INC;
                end
            end
            crws_pkg::S_ISSUE_CHK: begin
                if (i_stat.overflow) begin
                    o_cmd.op     = crws_pkg::OP_RESULT;
                    o_cmd.status = crws_pkg::ST_INVALID;
                end else begin
                    o_cmd.op = crws_pkg::OP_RST_IDX;
                end
            end
            crws_pkg::S_FREE: begin
                if (!i_stat.slot_valid) begin
                    o_cmd.op = crws_pkg::OP_ISSUE;
                end else if (i_stat.sidx_last) begin
                    o_cmd.op     = crws_pkg::OP_RESULT;
                    o_cmd.status = crws_pkg::ST_INVALID;
                end else begin
                    o_cmd.op = crws_pkg::OP_SIDX_INC;
                end
            end
            crws_pkg::S_CMP_MARK: o_cmd.op = crws_pkg::OP_CMP_MARK;
            crws_pkg::S_CMP_RD:   o_cmd.op = crws_pkg::OP_SLOT_RD;
            crws_pkg::S_CMP_CHK:  o_cmd.op = crws_pkg::OP_CMP_CHK;
            crws_pkg::S_CHK_RD:   o_cmd.op = crws_pkg::OP_SLOT_RD;
            crws_pkg::S_CHK_CHK: begin
                if (i_stat.chk_hit) begin
                    o_cmd.op     = crws_pkg::OP_RESULT;
                    o_cmd.status = crws_pkg::ST_OK;
                end else if (i_stat.sidx_last) begin
                    o_cmd.op = crws_pkg::OP_RESULT;
                end else begin
                    o_cmd.op = crws_pkg::OP_SIDX_INC;
                end
            end
            crws_pkg::S_UNI_RD: o_cmd.op = crws_pkg::OP_SLOT_RD;
            crws_pkg::S_UNI_CHK: begin
                if (i_stat.uni_hit) o_cmd.op = crws_pkg::OP_UNI_HIT;
                else if (i_stat.sidx_last) o_cmd.op = crws_pkg::OP_RESULT;
                else o_cmd.op = crws_pkg::OP_SIDX_INC;
            end
            crws_pkg::S_UNI_DO: begin
                o_cmd.op = i_stat.att_zero ? crws_pkg::OP_RESULT : crws_pkg::OP_UNI_DO;
            end
            default: o_cmd.op = crws_pkg::OP_NONE;
        endcase
    end

endmodule

>>> hdl/crws_dp.sv
// Datapath of the chunk request window scheduler: chunk and slot memories, counters.
module crws_dp #(
    parameter int WINDOW_SLOTS = 8,
    parameter int MAX_CHUNKS   = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  crws_pkg::t_cmd  i_cmd,
    input  crws_pkg::t_in   i_item,
    input  logic [10:0]     i_num_chunks,
    input  logic [63:0]     i_first_id,
    input  logic [31:0]     i_timeout,
    input  logic [7:0]      i_max_att,
    output crws_pkg::t_stat o_stat,
    output crws_pkg::t_out  o_result,
    output logic            o_strobe
);

    localparam int CIW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNTW = $clog2(MAX_CHUNKS + 1);
    localparam int SW   = $clog2(WINDOW_SLOTS);
    localparam int TW   = $clog2(WINDOW_SLOTS + 1);

    typedef struct packed {
        logic [63:0]    id;
        logic [63:0]    dl;
        logic [CIW-1:0] ch;
    } t_slot_ent;

    logic [8:0]  m_chunk [MAX_CHUNKS];
    logic        m_infl  [MAX_CHUNKS];
    t_slot_ent   m_slot  [WINDOW_SLOTS];

    crws_pkg::t_in      r_in;
    logic [CNTW-1:0]    r_active;
    logic [CNTW-1:0]    r_held_total;
    logic [TW-1:0]      r_infl_total;
    logic [CIW-1:0]     r_scan_pos;
    logic [CIW-1:0]     r_scan_i;
    logic [63:0]        r_next_id;
    logic               r_cancel;
    logic [WINDOW_SLOTS-1:0] r_valid;
    logic [SW-1:0]      r_sidx;
    logic [CNTW-1:0]    r_cidx;
    logic [8:0]         r_crd;
    logic               r_ird;
    t_slot_ent          r_srd;
    crws_pkg::t_out     r_res;
    logic               r_strobe;

    logic            c_re, c_we, f_we, s_we;
    logic [CIW-1:0]  c_ra, c_wa, f_wa;
    logic [8:0]      c_wd;
    logic            f_wd;
    t_slot_ent       s_wd;
    logic [CIW-1:0]  scan_i, scan_nxt;
    logic [64:0]     dl_sum;
    logic [63:0]     id_inc;
    logic            ch_match, id_match, do_free;

    assign scan_i   = (32'(r_scan_pos) >= 32'(r_active)) ? '0 : r_scan_pos;
    assign scan_nxt = (32'(scan_i) + 32'd1 >= 32'(r_active)) ? '0 : CIW'(32'(scan_i) + 32'd1);
    assign dl_sum   = {1'b0, r_in.now_ms} + {33'b0, i_timeout};
    assign id_inc   = r_next_id + 64'd1;
    assign ch_match = (32'(r_srd.ch) == 32'(r_in.chunk_sel));
    assign id_match = (r_srd.id == r_in.req_tag);

    always_comb begin
        o_stat.mode         = r_in.mode;
        o_stat.start_ok     = (i_num_chunks != 11'd0)
                              && (32'(i_num_chunks) <= 32'(MAX_CHUNKS))
                              && (i_first_id != 64'd0);
        o_stat.next_invalid = (r_in.now_ms == 64'd0) || (r_active == '0);
        o_stat.cancelled    = r_cancel;
        o_stat.cmp_ok       = (32'(r_in.chunk_sel) < 32'(r_active)) && !r_cancel;
        o_stat.chk_ok       = o_stat.cmp_ok && (r_in.req_tag != 64'd0);
        o_stat.uni_ok       = (r_in.req_tag != 64'd0) && !r_cancel;
        o_stat.all_held     = (r_held_total == r_active);
        o_stat.window_full  = (32'(r_infl_total) >= 32'(WINDOW_SLOTS));
        o_stat.cand         = !r_crd[8] && !r_ird && (r_crd[7:0] < i_max_att);
        o_stat.visits_done  = (r_cidx == r_active);
        o_stat.exh          = !r_crd[8] && (r_crd[7:0] >= i_max_att);
        o_stat.cidx_last    = (32'(r_cidx) + 32'd1 == 32'(r_active));
        o_stat.clr_last     = (32'(r_cidx) == 32'(MAX_CHUNKS - 1));
        o_stat.sidx_last    = (r_sidx == SW'(WINDOW_SLOTS - 1));
        o_stat.slot_valid   = r_valid[r_sidx];
        o_stat.chk_hit      = r_valid[r_sidx] && ch_match && id_match;
        o_stat.uni_hit      = r_valid[r_sidx] && id_match;
        o_stat.att_zero     = (r_crd[7:0] == 8'd0);
        o_stat.overflow     = dl_sum[64];
    end

    // memory port selection
    always_comb begin
        c_re = 1'b0;
        c_ra = CIW'(r_in.chunk_sel);
        c_we = 1'b0;
        c_wa = CIW'(r_cidx);
        c_wd = 9'd0;
        f_we = 1'b0;
        f_wa = CIW'(r_cidx);
        f_wd = 1'b0;
        s_we = 1'b0;
        s_wd.id = r_next_id;
        s_wd.dl = dl_sum[63:0];
        s_wd.ch = r_scan_i;
        do_free = 1'b0;
        case (i_cmd.op)
            crws_pkg::OP_CLR_ALL: begin
                c_we = 1'b1;
                f_we = 1'b1;
            end
            crws_pkg::OP_CLR_INFL: f_we = 1'b1;
            crws_pkg::OP_SCAN_RD: begin
                c_re = 1'b1;
                c_ra = scan_i;
            end
            crws_pkg::OP_CHUNK_RD: begin
                c_re = 1'b1;
                c_ra = CIW'(r_cidx);
            end
            crws_pkg::OP_CMP_RD: c_re = 1'b1;
            crws_pkg::OP_CMP_MARK: begin
                c_we = 1'b1;
                c_wa = CIW'(r_in.chunk_sel);
                c_wd = {1'b1, r_crd[7:0]};
            end
            crws_pkg::OP_EXP_CHK: do_free = r_valid[r_sidx] && (r_in.now_ms >= r_srd.dl);
            crws_pkg::OP_CMP_CHK: do_free = r_valid[r_sidx] && ch_match;
            crws_pkg::OP_UNI_HIT: begin
                c_re = 1'b1;
                c_ra = r_srd.ch;
            end
            crws_pkg::OP_UNI_DO: begin
                do_free = 1'b1;
                c_we    = 1'b1;
                c_wa    = r_srd.ch;
                c_wd    = {r_crd[8], r_crd[7:0] - 8'd1};
            end
            crws_pkg::OP_ISSUE: begin
                s_we = 1'b1;
                c_we = 1'b1;
                c_wa = r_scan_i;
                c_wd = {r_crd[8], r_crd[7:0] + 8'd1};
                f_we = 1'b1;
                f_wa = r_scan_i;
                f_wd = 1'b1;
            end
            default: c_re = 1'b0;
        endcase
        if (do_free) begin
            f_we = 1'b1;
            f_wa = r_srd.ch;
            f_wd = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_we) m_chunk[c_wa] <= c_wd;
        if (f_we) m_infl[f_wa] <= f_wd;
        if (c_re) begin
            r_crd <= m_chunk[c_ra];
            r_ird <= m_infl[c_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) m_slot[r_sidx] <= s_wd;
        if (i_cmd.op == crws_pkg::OP_SLOT_RD) r_srd <= m_slot[r_sidx];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == crws_pkg::OP_LOAD) r_in <= i_item;
        if (i_cmd.op == crws_pkg::OP_SCAN_RD) r_scan_i <= scan_i;
        if (i_cmd.op == crws_pkg::OP_START_INIT) r_next_id <= i_first_id;
        else if (i_cmd.op == crws_pkg::OP_ISSUE)
            r_next_id <= (id_inc == 64'd0) ? 64'd1 : id_inc;
        if (i_cmd.op == crws_pkg::OP_ISSUE) begin
            r_res.status         <= crws_pkg::ST_REQUEST;
            r_res.issued_tag     <= r_next_id;
            r_res.due_ms         <= dl_sum[63:0];
            r_res.issued_chunk   <= 10'(r_scan_i);
            r_res.attempt_number <= r_crd[7:0] + 8'd1;
        end else if (i_cmd.op == crws_pkg::OP_RESULT) begin
            r_res.status         <= i_cmd.status;
            r_res.issued_tag     <= 64'd0;
            r_res.due_ms         <= 64'd0;
            r_res.issued_chunk   <= 10'd0;
            r_res.attempt_number <= 8'd0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_held_total <= '0;
            r_infl_total <= '0;
            r_scan_pos   <= '0;
            r_cancel     <= 1'b0;
            r_valid      <= '0;
            r_sidx       <= '0;
            r_cidx       <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.op == crws_pkg::OP_ISSUE) || (i_cmd.op == crws_pkg::OP_RESULT);
            if (do_free) begin
                r_valid[r_sidx] <= 1'b0;
                r_infl_total    <= r_infl_total - TW'(1);
            end
            case (i_cmd.op)
                crws_pkg::OP_START_INIT: begin
                    r_active     <= CNTW'(i_num_chunks);
                    r_held_total <= '0;
                    r_infl_total <= '0;
                    r_scan_pos   <= '0;
                    r_cancel     <= 1'b0;
                    r_valid      <= '0;
                    r_cidx       <= '0;
                end
                crws_pkg::OP_CANCEL_INIT: begin
                    r_cancel     <= 1'b1;
                    r_valid      <= '0;
                    r_infl_total <= '0;
                    r_cidx       <= '0;
                end
                crws_pkg::OP_CLR_ALL, crws_pkg::OP_CLR_INFL, crws_pkg::OP_SCAN_RD,
                crws_pkg::OP_CIDX_INC: begin
                    r_cidx <= r_cidx + CNTW'(1);
                    if (i_cmd.op == crws_pkg::OP_SCAN_RD) r_scan_pos <= scan_nxt;
                end
                crws_pkg::OP_RST_IDX: begin
                    r_sidx <= '0;
                    r_cidx <= '0;
                end
                crws_pkg::OP_EXP_CHK, crws_pkg::OP_CMP_CHK, crws_pkg::OP_SIDX_INC: begin
                    r_sidx <= r_sidx + SW'(1);
                end
                crws_pkg::OP_CMP_MARK: begin
                    r_sidx <= '0;
                    if (!r_crd[8]) r_held_total <= r_held_total + CNTW'(1);
                end
                crws_pkg::OP_UNI_DO: r_scan_pos <= r_srd.ch;
                crws_pkg::OP_ISSUE: begin
                    r_valid[r_sidx] <= 1'b1;
                    r_infl_total    <= r_infl_total + TW'(1);
                end
                default: r_sidx <= r_sidx;
            endcase
        end
    end

    assign o_result = r_res;
    assign o_strobe = r_strobe;

endmodule

>>> hdl/chunk_request_window_scheduler_unit.sv
// Top level of the chunk request window scheduler: configuration registers and core.
//
// Commands enter on start while busy is low; every command returns exactly one
// result word, shown on o_result for one cycle with o_strobe high. The receiver
// cannot stall, so capture each word on the cycle it appears. One command runs
// at a time. Start sweeps the chunk memories; cancel sweeps the in-flight bits;
// next frees expired slots, runs the round-robin scan over the chunks and, for
// an eligible chunk, looks for a free slot, or sweeps the chunks for exhaustion
// when nothing is eligible; complete, check response and unissue walk the slot
// memory. Configuration words are written through i_cfg_we / i_cfg_index /
// i_cfg_data and take effect at once; the chunk total is latched only by a
// start command. No clearing pass follows reset.
module chunk_request_window_scheduler_unit #(
    parameter int WINDOW_SLOTS = 8,
    parameter int MAX_CHUNKS   = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [63:0]    i_cfg_data,
    input  logic           start,
    input  crws_pkg::t_in  i_item,
    output logic           busy,
    output crws_pkg::t_out o_result,
    output logic           o_strobe
);

`include "chunk_request_window_scheduler_unit_macros.svh"

    logic [10:0] r_num_chunks;
    logic [63:0] r_first_id;
    logic [31:0] r_timeout;
    logic [7:0]  r_max_att;

    crws_pkg::t_cmd  cmd;
    crws_pkg::t_stat stat;

    // hold configuration words; take each write at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_chunks <= 11'd1;
            r_first_id   <= 64'd1;
            r_timeout    <= 32'd1000;
            r_max_att    <= 8'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                crws_pkg::REG_NUM_CHUNKS:   r_num_chunks <= i_cfg_data[10:0];
                crws_pkg::REG_FIRST_ID:     r_first_id   <= i_cfg_data;
                crws_pkg::REG_TIMEOUT:      r_timeout    <= i_cfg_data[31:0];
                crws_pkg::REG_MAX_ATTEMPTS: r_max_att    <= i_cfg_data[7:0];
                default:                    r_max_att    <= r_max_att;
            endcase
        end
    end

    crws_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    crws_dp #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .MAX_CHUNKS   (MAX_CHUNKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_item       (i_item),
        .i_num_chunks (r_num_chunks),
        .i_first_id   (r_first_id),
        .i_timeout    (r_timeout),
        .i_max_att    (r_max_att),
        .o_stat       (stat),
        .o_result     (o_result),
        .o_strobe     (o_strobe)
    );

    // a result word is only ever shown once the command has finished
    `CRWS_AST_IMP(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "result while busy")
    `CRWS_AST_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept did not go busy")
    `CRWS_AST_IMP(a_req_id_nz, i_clk, i_rst_n, o_strobe && (o_result.status == crws_pkg::ST_REQUEST), o_result.issued_tag != 64'd0, "request with zero id")

endmodule
